// ===== sv/rgbp_pkg.sv =====
package rgbp_pkg;

    localparam int unsigned CFG_DATA_W  = 23;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CNT_CFG_W   = 23;
    localparam int unsigned ADDR_W      = 21;
    localparam int unsigned CODE_W      = 4;
    localparam int unsigned DIST_W      = 18;
    localparam int unsigned PAL_SIZE    = 6;

    localparam int unsigned MAX_FRAME_PIXELS_DEF = 4194304;

    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_RED_BLUE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLACK_LIMIT        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_LIMIT        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PIXELS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DISPLAY_PIXELS = 3'd4;

    localparam logic [7:0]           BLACK_LIMIT_RST = 8'd8;
    localparam logic [7:0]           WHITE_LIMIT_RST = 8'd247;
    localparam logic [CNT_CFG_W-1:0] FRAME_PIX_RST   = 23'd1920000;
    localparam logic [CNT_CFG_W-1:0] MIN_DISP_RST    = 23'd1728000;
    localparam logic [7:0]           CHAN_FULL       = 8'd255;

    localparam logic [CODE_W-1:0] CODE_BLACK  = 4'h0;
    localparam logic [CODE_W-1:0] CODE_WHITE  = 4'h1;
    localparam logic [CODE_W-1:0] CODE_YELLOW = 4'h2;
    localparam logic [CODE_W-1:0] CODE_RED    = 4'h3;
    localparam logic [CODE_W-1:0] CODE_BLUE   = 4'h5;
    localparam logic [CODE_W-1:0] CODE_GREEN  = 4'h6;

    // palette channel at full scale: {r, g, b}
    localparam logic [2:0] PAL_RGB [PAL_SIZE] = '{
        3'b000, 3'b111, 3'b110, 3'b100, 3'b001, 3'b010
    };
    localparam logic [CODE_W-1:0] PAL_CODE [PAL_SIZE] = '{
        CODE_BLACK, CODE_WHITE, CODE_YELLOW, CODE_RED, CODE_BLUE, CODE_GREEN
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        packed_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              byte_valid;
        logic              frame_done;
        logic              frame_ok;
    } out_item_t;

    typedef struct packed {
        logic                 swap_red_blue;
        logic [7:0]           black_limit;
        logic [7:0]           white_limit;
        logic [CNT_CFG_W-1:0] frame_pixels;
        logic [CNT_CFG_W-1:0] min_display_pixels;
    } rgbp_cfg_t;

endpackage

// ===== sv/rgbp_classify.sv =====
module rgbp_classify
    import rgbp_pkg::*;
(
    input  in_item_t           pixel,
    input  rgbp_cfg_t          cfg,
    output logic [CODE_W-1:0]  code
);

    logic [7:0]        r, g, b;
    logic [15:0]       sq_lo [3];
    logic [15:0]       sq_hi [3];
    logic [DIST_W-1:0] pal_err [PAL_SIZE];
    logic [DIST_W-1:0] best;
    logic [CODE_W-1:0] best_code;
    logic              is_black, is_white;

    always_comb
    begin
        r = cfg.swap_red_blue ? pixel.blue : pixel.red;
        g = pixel.green;
        b = cfg.swap_red_blue ? pixel.red : pixel.blue;
    end

    always_comb
    begin
        sq_lo[0] = 16'(r) * 16'(r);
        sq_lo[1] = 16'(g) * 16'(g);
        sq_lo[2] = 16'(b) * 16'(b);
        sq_hi[0] = 16'(CHAN_FULL - r) * 16'(CHAN_FULL - r);
        sq_hi[1] = 16'(CHAN_FULL - g) * 16'(CHAN_FULL - g);
        sq_hi[2] = 16'(CHAN_FULL - b) * 16'(CHAN_FULL - b);
    end

    always_comb
    begin
        for (int i = 0; i < PAL_SIZE; i++)
        begin
            pal_err[i] = DIST_W'(PAL_RGB[i][2] ? sq_hi[0] : sq_lo[0])
                       + DIST_W'(PAL_RGB[i][1] ? sq_hi[1] : sq_lo[1])
                       + DIST_W'(PAL_RGB[i][0] ? sq_hi[2] : sq_lo[2]);
        end
    end

    // earliest entry wins a tie
    always_comb
    begin
        best      = pal_err[0];
        best_code = PAL_CODE[0];
        for (int i = 1; i < PAL_SIZE; i++)
        begin
            if (pal_err[i] < best)
            begin
                best      = pal_err[i];
                best_code = PAL_CODE[i];
            end
        end
    end

    always_comb
    begin
        is_black = (r < cfg.black_limit) && (g < cfg.black_limit) && (b < cfg.black_limit);
        is_white = (r > cfg.white_limit) && (g > cfg.white_limit) && (b > cfg.white_limit);
        if (is_black)
            code = CODE_BLACK;
        else if (is_white)
            code = CODE_WHITE;
        else
            code = best_code;
    end

endmodule

// ===== sv/rgbp_pack.sv =====
module rgbp_pack
    import rgbp_pkg::*;
#(
    parameter int unsigned MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    input  logic              pix_eof,
    input  logic [CODE_W-1:0] pix_code,
    input  rgbp_cfg_t         cfg,
    output logic              pix_move,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item
);

    localparam int unsigned CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int unsigned CMP_W  = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
    localparam int unsigned CNTX_W = (CNT_W > ADDR_W + 1) ? CNT_W : ADDR_W + 1;
    localparam logic [CMP_W-1:0] MAX_PIX = CMP_W'(MAX_FRAME_PIXELS);

    logic [CNT_W-1:0]  count_reg, count_next, count_inc;
    logic [CODE_W-1:0] held_reg, held_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, res;
    logic              has_result, take;
    logic [CMP_W-1:0]  limit;
    logic [CNTX_W-1:0] cnt_x, inc_x;

    always_comb
    begin
        limit     = (CMP_W'(cfg.frame_pixels) > MAX_PIX) ? MAX_PIX : CMP_W'(cfg.frame_pixels);
        take      = CMP_W'(count_reg) < limit;
        count_inc = take ? CNT_W'(count_reg + 1'b1) : count_reg;
        cnt_x     = CNTX_W'(count_reg);
        inc_x     = CNTX_W'(count_inc);

        held_next  = held_reg;
        res        = '0;
        has_result = 1'b0;
        if (take)
        begin
            if (!count_reg[0])
                held_next = pix_code;
            else
            begin
                res.byte_valid   = 1'b1;
                res.packed_byte  = {held_reg, pix_code};
                res.byte_address = cnt_x[ADDR_W:1];
                has_result       = 1'b1;
            end
        end

        count_next = count_inc;
        if (pix_eof)
        begin
            has_result     = 1'b1;
            res.frame_done = 1'b1;
            res.frame_ok   = CMP_W'(count_inc) >= CMP_W'(cfg.min_display_pixels);
            // odd count at frame end: flush the half byte
            if (!res.byte_valid && count_inc[0])
            begin
                res.byte_valid   = 1'b1;
                res.packed_byte  = {held_next, CODE_W'(0)};
                res.byte_address = inc_x[ADDR_W:1];
            end
            count_next = '0;
            held_next  = '0;
        end
    end

    assign pix_move = pix_valid && (!has_result || !out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (pix_move && has_result)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pix_move)
            begin
                count_reg <= count_next;
                held_reg  <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_move && has_result)
            out_item_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== sv/rgb_to_six_color_nibble_packer.sv =====
// Quantizes a 24-bit pixel stream to a six-color palette (nearest by squared RGB
// distance, black/white fast paths) and packs two 4-bit codes per byte, even pixel
// in the upper nibble, each byte with its frame address. Throughput is one pixel per
// clock while the output is not stalled; each pixel passes the input register, then
// is classified and packed into the result register. The last pixel of a frame always
// yields one result with frame_done set, flushing a half byte if one is pending.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
module rgb_to_six_color_nibble_packer
    import rgbp_pkg::*;
#(
    parameter int unsigned MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_item
);

    rgbp_cfg_t         cfg_reg;
    in_item_t          pix_reg;
    logic              pix_valid_reg, pix_valid_next;
    logic              pix_move;
    logic [CODE_W-1:0] code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swap_red_blue      <= 1'b0;
            cfg_reg.black_limit        <= BLACK_LIMIT_RST;
            cfg_reg.white_limit        <= WHITE_LIMIT_RST;
            cfg_reg.frame_pixels       <= FRAME_PIX_RST;
            cfg_reg.min_display_pixels <= MIN_DISP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SWAP_RED_BLUE:      cfg_reg.swap_red_blue      <= cfg_data[0];
                CFG_BLACK_LIMIT:        cfg_reg.black_limit        <= cfg_data[7:0];
                CFG_WHITE_LIMIT:        cfg_reg.white_limit        <= cfg_data[7:0];
                CFG_FRAME_PIXELS:       cfg_reg.frame_pixels       <= cfg_data[CNT_CFG_W-1:0];
                CFG_MIN_DISPLAY_PIXELS: cfg_reg.min_display_pixels <= cfg_data[CNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_stall = pix_valid_reg && !pix_move;

    always_comb
    begin
        pix_valid_next = pix_valid_reg && !pix_move;
        if (in_valid && !in_stall)
            pix_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else
            pix_valid_reg <= pix_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            pix_reg <= in_item;
    end

    rgbp_classify u_classify (
        .pixel (pix_reg),
        .cfg   (cfg_reg),
        .code  (code)
    );

    rgbp_pack #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid_reg),
        .pix_eof   (pix_reg.end_of_frame),
        .pix_code  (code),
        .cfg       (cfg_reg),
        .pix_move  (pix_move),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== sim/tb_rgb_to_six_color_nibble_packer.sv =====
module tb_rgb_to_six_color_nibble_packer;
    import rgbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       eof;
        logic       typed;
        out_item_t  res;
    } pixel_row_t;

    // even pixel lands in the upper nibble
    localparam pixel_row_t PIXEL_TABLE [20] = '{
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1,
            '{{CODE_BLACK, CODE_WHITE}, 21'd0, 1'b1, 1'b0, 1'b0}},
        '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1,
            '{{CODE_YELLOW, CODE_RED}, 21'd1, 1'b1, 1'b0, 1'b0}},
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b0, '0},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b1,
            '{{CODE_BLUE, CODE_GREEN}, 21'd2, 1'b1, 1'b0, 1'b0}},
        '{8'd7,   8'd7,   8'd7,   1'b0, 1'b0, '0},
        '{8'd248, 8'd248, 8'd248, 1'b0, 1'b1,
            '{{CODE_BLACK, CODE_WHITE}, 21'd3, 1'b1, 1'b0, 1'b0}},
        '{8'd8,   8'd8,   8'd8,   1'b0, 1'b0, '0},
        '{8'd247, 8'd247, 8'd247, 1'b0, 1'b0, '0},
        '{8'd127, 8'd128, 8'd0,   1'b0, 1'b0, '0},
        '{8'd128, 8'd127, 8'd255, 1'b0, 1'b0, '0},
        '{8'd127, 8'd127, 8'd128, 1'b0, 1'b0, '0},
        '{8'd128, 8'd128, 8'd127, 1'b0, 1'b0, '0},
        '{8'd200, 8'd60,  8'd40,  1'b0, 1'b0, '0},
        '{8'd30,  8'd90,  8'd220, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   8'd255, 1'b1, 1'b1,
            '{{CODE_BLUE, CODE_BLACK}, 21'd8, 1'b1, 1'b1, 1'b0}},
        '{8'd255, 8'd0,   8'd0,   1'b1, 1'b1,
            '{{CODE_RED, CODE_BLACK}, 21'd0, 1'b1, 1'b1, 1'b0}},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
            '{{CODE_BLACK, CODE_WHITE}, 21'd0, 1'b1, 1'b1, 1'b0}}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;

    rgbp_cfg_t            regs = '{1'b0, BLACK_LIMIT_RST, WHITE_LIMIT_RST,
                                   FRAME_PIX_RST, MIN_DISP_RST};
    logic [CNT_CFG_W-1:0] pix_count = '0;
    logic [CODE_W-1:0]    held_code = '0;
    out_item_t            bytes_due [$];
    out_item_t            want;
    bit                   steady = 1'b0;
    int                   pixels_sent = 0;
    int                   items_checked = 0;
    int                   frames_closed = 0;
    int                   settings_used = 1;
    int                   mismatches = 0;

    rgb_to_six_color_nibble_packer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #1 clk = ~clk;

    function automatic logic [CODE_W-1:0] nearest_code(input logic [7:0] r, g, b);
        int unsigned best;
        int unsigned d;
        int dr;
        int dg;
        int db;
        logic [CODE_W-1:0] code;
        if (r < regs.black_limit && g < regs.black_limit && b < regs.black_limit)
            return CODE_BLACK;
        if (r > regs.white_limit && g > regs.white_limit && b > regs.white_limit)
            return CODE_WHITE;
        best = 32'hFFFF_FFFF;
        code = CODE_WHITE;
        for (int i = 0; i < PAL_SIZE; i++)
        begin
            dr = int'(r) - (PAL_RGB[i][2] ? int'(CHAN_FULL) : 0);
            dg = int'(g) - (PAL_RGB[i][1] ? int'(CHAN_FULL) : 0);
            db = int'(b) - (PAL_RGB[i][0] ? int'(CHAN_FULL) : 0);
            d = dr * dr + dg * dg + db * db;
            if (d < best)
            begin
                best = d;
                code = PAL_CODE[i];
            end
        end
        return code;
    endfunction

    function automatic bit pack_pixel(input in_item_t px, output out_item_t res);
        logic [7:0]           r;
        logic [7:0]           b;
        logic [CODE_W-1:0]    code;
        logic [CNT_CFG_W-1:0] lim;
        logic [CNT_CFG_W-1:0] last;
        bit                   hit;
        hit = 1'b0;
        res = '0;
        r = regs.swap_red_blue ? px.blue : px.red;
        b = regs.swap_red_blue ? px.red : px.blue;
        code = nearest_code(r, px.green, b);
        lim = (regs.frame_pixels > MAX_FRAME_PIXELS_DEF) ?
              CNT_CFG_W'(MAX_FRAME_PIXELS_DEF) : regs.frame_pixels;
        if (pix_count < lim)
        begin
            if (!pix_count[0])
                held_code = code;
            else
            begin
                hit = 1'b1;
                res.packed_byte = {held_code, code};
                res.byte_address = pix_count[ADDR_W:1];
                res.byte_valid = 1'b1;
            end
            pix_count = pix_count + 1'b1;
        end
        if (px.end_of_frame)
        begin
            res.frame_done = 1'b1;
            res.frame_ok = (pix_count >= regs.min_display_pixels);
            if (!hit && pix_count[0])
            begin
                last = pix_count - 1'b1;
                res.packed_byte = {held_code, CODE_BLACK};
                res.byte_address = last[ADDR_W:1];
                res.byte_valid = 1'b1;
            end
            hit = 1'b1;
            pix_count = '0;
            held_code = '0;
            frames_closed++;
        end
        return hit;
    endfunction

    function automatic in_item_t rand_pixel(input int eof_pct);
        in_item_t   px;
        logic [7:0] ch [3];
        logic [7:0] lim;
        int         mode;
        int         pick;
        int         noise;
        mode = $urandom_range(0, 9);
        pick = $urandom_range(0, PAL_SIZE - 1);
        lim = $urandom_range(0, 1) ? regs.black_limit : regs.white_limit;
        for (int k = 0; k < 3; k++)
        begin
            noise = $urandom_range(0, 40);
            case (mode) inside
                [4:5]: ch[k] = PAL_RGB[pick][2-k] ? CHAN_FULL - 8'(noise) : 8'(noise);
                [6:7]: ch[k] = 8'(int'(lim) + int'($urandom_range(0, 2)) - 1);
                8: ch[k] = $urandom_range(0, 1) ? CHAN_FULL : 8'd0;
                default: ch[k] = 8'($urandom_range(0, 255));
            endcase
        end
        px.red = ch[0];
        px.green = ch[1];
        px.blue = ch[2];
        px.end_of_frame = ($urandom_range(0, 99) < eof_pct);
        return px;
    endfunction

    task automatic send_pixel(input in_item_t px, input bit typed, input out_item_t typed_res);
        out_item_t res;
        bit        hit;
        while (!steady && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = pack_pixel(px, res);
        if (typed)
            bytes_due.push_back(typed_res);
        else if (hit)
            bytes_due.push_back(res);
        pixels_sent++;
    endtask

    task automatic write_registers(input rgbp_cfg_t setting);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SWAP_RED_BLUE;
        cfg_data <= CFG_DATA_W'(setting.swap_red_blue);
        @(posedge clk);
        cfg_index <= CFG_BLACK_LIMIT;
        cfg_data <= CFG_DATA_W'(setting.black_limit);
        @(posedge clk);
        cfg_index <= CFG_WHITE_LIMIT;
        cfg_data <= CFG_DATA_W'(setting.white_limit);
        @(posedge clk);
        cfg_index <= CFG_FRAME_PIXELS;
        cfg_data <= CFG_DATA_W'(setting.frame_pixels);
        @(posedge clk);
        cfg_index <= CFG_MIN_DISPLAY_PIXELS;
        cfg_data <= CFG_DATA_W'(setting.min_display_pixels);
        @(posedge clk);
        cfg_write <= 1'b0;
        regs = setting;
        settings_used++;
    endtask

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 27);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: byte %h addr %0d valid %b done %b ok %b",
                             out_item.packed_byte, out_item.byte_address,
                             out_item.byte_valid, out_item.frame_done, out_item.frame_ok);
            end
            else
            begin
                want = bytes_due.pop_front();
                items_checked++;
                if (out_item.packed_byte !== want.packed_byte ||
                    out_item.byte_address !== want.byte_address ||
                    out_item.byte_valid !== want.byte_valid ||
                    out_item.frame_done !== want.frame_done ||
                    out_item.frame_ok !== want.frame_ok)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp byte %h addr %0d v%b d%b ok%b, got %h %0d v%b d%b ok%b",
                                 want.packed_byte, want.byte_address, want.byte_valid,
                                 want.frame_done, want.frame_ok,
                                 out_item.packed_byte, out_item.byte_address,
                                 out_item.byte_valid, out_item.frame_done,
                                 out_item.frame_ok);
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("tb_rgb_to_six_color_nibble_packer: done, errors");
        $finish;
    end

    initial
    begin
        rgbp_cfg_t setting;
        int        eof_pct;
        in_item_t  px;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PIXEL_TABLE[i])
        begin
            px = '{red: PIXEL_TABLE[i].r, green: PIXEL_TABLE[i].g,
                   blue: PIXEL_TABLE[i].b, end_of_frame: PIXEL_TABLE[i].eof};
            send_pixel(px, PIXEL_TABLE[i].typed, PIXEL_TABLE[i].res);
        end
        in_valid <= 1'b0;

        for (int ph = 0; ph < 10; ph++)
        begin
            while (bytes_due.size() != 0)
                @(posedge clk);
            repeat (6) @(posedge clk);
            setting.swap_red_blue = 1'($urandom_range(0, 1));
            setting.black_limit = 8'($urandom_range(0, 255));
            setting.white_limit = 8'($urandom_range(0, 255));
            setting.frame_pixels = CNT_CFG_W'($urandom_range(1, 24));
            setting.min_display_pixels = CNT_CFG_W'($urandom_range(0, 26));
            eof_pct = $urandom_range(3, 15);
            steady = 1'b0;
            case (ph)
                0: setting = '{1'b1, 8'd0, 8'd255, 23'h7F_FFFF, 23'd0};
                1: setting = '{1'b0, 8'd255, 8'd0, 23'd0, 23'd0};
                2:
                begin
                    setting.frame_pixels = 23'd1;
                    setting.min_display_pixels = 23'd1;
                end
                3:
                begin
                    setting.frame_pixels = CNT_CFG_W'(MAX_FRAME_PIXELS_DEF);
                    setting.min_display_pixels = CNT_CFG_W'(MAX_FRAME_PIXELS_DEF);
                    eof_pct = 1;
                    steady = 1'b1;
                end
                default: ;
            endcase
            write_registers(setting);
            for (int n = 0; n < 103; n++)
                send_pixel(rand_pixel(eof_pct), 1'b0, '0);
            in_valid <= 1'b0;
        end
        steady = 1'b0;

        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d pixels sent over %0d register settings, %0d frames closed",
                 pixels_sent, settings_used, frames_closed);
        $display("%0d output items checked, %0d mismatches", items_checked, mismatches);
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("tb_rgb_to_six_color_nibble_packer: done, clean");
        else
            $display("tb_rgb_to_six_color_nibble_packer: done, errors");
        $finish;
    end

endmodule
